[sv/hrhp_pkg.sv]
// shared types, codes and constant tables for the http request header parser
// no dependencies
package hrhp_pkg;

  typedef enum logic [3:0] {
    PH_LINE     = 4'd0,
    PH_LINE_CR  = 4'd1,
    PH_EOL      = 4'd2,
    PH_EOL_CR   = 4'd3,
    PH_SKIP     = 4'd4,
    PH_NAME     = 4'd5,
    PH_VALUE    = 4'd6,
    PH_VALUE_CR = 4'd7,
    PH_DONE     = 4'd8,
    PH_BAD      = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_HOST  = 2'd1,
    KIND_AGENT = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    TAG_NONE     = 3'd0,
    TAG_METHOD   = 3'd1,
    TAG_RESOURCE = 3'd2,
    TAG_VERSION  = 3'd3,
    TAG_HOST     = 3'd4,
    TAG_AGENT    = 3'd5
  } tag_e;

  typedef enum logic [1:0] {
    STAT_PENDING   = 2'd0,
    STAT_COMPLETE  = 2'd1,
    STAT_MALFORMED = 2'd2
  } stat_e;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] token_count;
    logic       in_token;
    logic [3:0] name_pos;
    logic       host_cand;
    logic       agent_cand;
    kind_e      kind;
    logic       host_seen;
    logic       agent_seen;
    logic       value_nonempty;
  } parse_st_t;

  typedef struct packed {
    logic host;
    logic agent;
  } match_t;

  localparam parse_st_t ST_RESET = '{
    phase:          PH_LINE,
    token_count:    2'd0,
    in_token:       1'b0,
    name_pos:       4'd0,
    host_cand:      1'b1,
    agent_cand:     1'b1,
    kind:           KIND_OTHER,
    host_seen:      1'b0,
    agent_seen:     1'b0,
    value_nonempty: 1'b0
  };

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] TOKEN_MAX = 2'd3;
  localparam logic [3:0] POS_MAX   = 4'd15;
  localparam logic [3:0] HOST_LEN  = 4'd4;
  localparam logic [3:0] AGENT_LEN = 4'd10;

  localparam logic [7:0] HOST_WORD [4] = '{8'h48, 8'h4f, 8'h53, 8'h54};
  localparam logic [7:0] AGENT_WORD [10] = '{
    8'h55, 8'h53, 8'h45, 8'h52, 8'h2d, 8'h41, 8'h47, 8'h45, 8'h4e, 8'h54
  };

  function automatic logic [7:0] to_upper(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7a) begin
      r = b - 8'd32;
    end
    return r;
  endfunction

endpackage

[sv/hrhp_name_match.sv]
// compares one header name byte against the host and user-agent words
// depends on hrhp_pkg
module hrhp_name_match import hrhp_pkg::*; (
  input  logic [7:0] byte_i,
  input  logic [3:0] pos_i,
  output match_t     match_o
);

  logic [7:0] upper;

  assign upper = to_upper(byte_i);

  always_comb begin
    match_o.host  = 1'b0;
    match_o.agent = 1'b0;
    if (pos_i < HOST_LEN) begin
      match_o.host = (HOST_WORD[pos_i[1:0]] == upper);
    end
    if (pos_i < AGENT_LEN) begin
      match_o.agent = (AGENT_WORD[pos_i] == upper);
    end
  end

endmodule

[sv/hrhp_step.sv]
// next parse state and result for one request byte
// depends on hrhp_pkg and hrhp_name_match
module hrhp_step import hrhp_pkg::*; (
  input  parse_st_t  st_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  output parse_st_t  st_o,
  output tag_e       tag_o,
  output stat_e      status_o
);

  parse_st_t  cur;
  logic       is_cr, is_lf, is_sp, is_colon, is_ws;
  logic       name_fresh, name_go;
  logic [3:0] ctx_pos;
  logic       ctx_host, ctx_agent;
  match_t     hit;
  logic [1:0] next_tc;
  tag_e       tag_raw;

  assign cur      = first_byte_i ? ST_RESET : st_i;
  assign is_cr    = (data_byte_i == CH_CR);
  assign is_lf    = (data_byte_i == CH_LF);
  assign is_sp    = (data_byte_i == CH_SPACE);
  assign is_colon = (data_byte_i == CH_COLON);
  assign is_ws    = is_cr || is_lf || is_sp;

  assign name_fresh = !is_ws && ((cur.phase == PH_EOL) || (cur.phase == PH_EOL_CR && !is_lf)
                      || (cur.phase == PH_SKIP));
  assign name_go    = name_fresh || (cur.phase == PH_NAME);
  assign ctx_pos    = name_fresh ? 4'd0 : cur.name_pos;
  assign ctx_host   = name_fresh ? 1'b1 : cur.host_cand;
  assign ctx_agent  = name_fresh ? 1'b1 : cur.agent_cand;
  assign next_tc    = cur.token_count + 2'd1;

  hrhp_name_match u_match (
    .byte_i  (data_byte_i),
    .pos_i   (ctx_pos),
    .match_o (hit)
  );

  // next state
  always_comb begin
    st_o = cur;
    unique case (cur.phase)
      PH_LINE: begin
        if (is_sp) begin
          st_o.in_token = 1'b0;
        end else if (is_cr) begin
          st_o.phase = PH_LINE_CR;
        end else if (!cur.in_token) begin
          if (cur.token_count == TOKEN_MAX) begin
            st_o.phase = PH_BAD;
          end else begin
            st_o.in_token    = 1'b1;
            st_o.token_count = next_tc;
          end
        end
      end
      PH_LINE_CR, PH_VALUE_CR: begin
        st_o.phase = is_lf ? PH_EOL : PH_BAD;
      end
      PH_EOL: begin
        if (is_cr) begin
          st_o.phase = PH_EOL_CR;
        end else if (is_lf || is_sp) begin
          st_o.phase = PH_SKIP;
        end
      end
      PH_EOL_CR: begin
        if (is_lf) begin
          st_o.phase = PH_DONE;
        end else if (is_cr || is_sp) begin
          st_o.phase = PH_SKIP;
        end
      end
      PH_SKIP, PH_NAME, PH_DONE: begin
      end
      PH_VALUE: begin
        if (is_cr) begin
          st_o.phase = cur.value_nonempty ? PH_VALUE_CR : PH_BAD;
        end else if (!(is_sp && !cur.value_nonempty)) begin
          st_o.value_nonempty = 1'b1;
        end
      end
      default: begin
        st_o.phase = PH_BAD;
      end
    endcase

    if (name_go) begin
      st_o.phase      = PH_NAME;
      st_o.name_pos   = ctx_pos;
      st_o.host_cand  = ctx_host;
      st_o.agent_cand = ctx_agent;
      if (name_fresh) begin
        st_o.kind           = KIND_OTHER;
        st_o.value_nonempty = 1'b0;
      end
      if (is_cr || is_lf) begin
        st_o.phase = PH_BAD;
      end else if (is_colon) begin
        st_o.phase          = PH_VALUE;
        st_o.value_nonempty = 1'b0;
        if (ctx_host && ctx_pos == HOST_LEN && !cur.host_seen) begin
          st_o.kind      = KIND_HOST;
          st_o.host_seen = 1'b1;
        end else if (ctx_agent && ctx_pos == AGENT_LEN && !cur.agent_seen) begin
          st_o.kind       = KIND_AGENT;
          st_o.agent_seen = 1'b1;
        end else begin
          st_o.kind = KIND_OTHER;
        end
      end else begin
        st_o.host_cand  = ctx_host && hit.host;
        st_o.agent_cand = ctx_agent && hit.agent;
        if (ctx_pos < POS_MAX) begin
          st_o.name_pos = ctx_pos + 4'd1;
        end
      end
    end

    if (last_byte_i && st_o.phase != PH_DONE) begin
      st_o.phase = PH_BAD;
    end
  end

  // result
  always_comb begin
    tag_raw = TAG_NONE;
    if (cur.phase == PH_LINE && !is_sp && !is_cr) begin
      unique case (cur.in_token ? cur.token_count : next_tc)
        2'd1:    tag_raw = TAG_METHOD;
        2'd2:    tag_raw = TAG_RESOURCE;
        2'd3:    tag_raw = TAG_VERSION;
        default: tag_raw = TAG_NONE;
      endcase
    end else if (cur.phase == PH_VALUE && !is_cr && !(is_sp && !cur.value_nonempty)) begin
      unique case (cur.kind)
        KIND_HOST:  tag_raw = TAG_HOST;
        KIND_AGENT: tag_raw = TAG_AGENT;
        default:    tag_raw = TAG_NONE;
      endcase
    end

    tag_o    = tag_raw;
    status_o = STAT_PENDING;
    if (st_o.phase == PH_DONE) begin
      status_o = STAT_COMPLETE;
    end else if (st_o.phase == PH_BAD) begin
      status_o = STAT_MALFORMED;
      tag_o    = TAG_NONE;
    end
  end

endmodule

[sv/http_request_header_parser.sv]
// the result of an accepted byte is held on the output register in the following cycle
// throughput: one byte per cycle, unless a full output register is held by a low out_ready_i
// a new byte is taken whenever the output register is empty or being drained
// reset clears the parse state to the start of a request line and empties the output
// depends on hrhp_pkg and hrhp_step
module http_request_header_parser import hrhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] field_tag_o,
  output logic [1:0] parse_status_o
);

  parse_st_t state_q, state_d;
  tag_e      tag_d, tag_q;
  stat_e     status_d, status_q;
  logic      out_valid_q;
  logic      in_accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  hrhp_step u_step (
    .st_i         (state_q),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .st_o         (state_d),
    .tag_o        (tag_d),
    .status_o     (status_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      tag_q    <= tag_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign field_tag_o    = tag_q;
  assign parse_status_o = status_q;

  a_final_no_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (parse_status_o != STAT_PENDING) |-> field_tag_o == TAG_NONE)
    else $error("tag on a finished or malformed result");

  a_last_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_byte_i |=> parse_status_o != STAT_PENDING)
    else $error("last byte left the request pending");

  a_version_third_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_tag_o == TAG_VERSION |-> state_q.token_count == TOKEN_MAX)
    else $error("version tag without a third token");

  a_first_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && first_byte_i && !last_byte_i
    |=> state_q.phase == PH_LINE || state_q.phase == PH_LINE_CR)
    else $error("first byte did not restart the request line");

endmodule
